>>> hw/rtl/first_fit_heap_allocator_core_assert.svh
// Assertion macros shared by the heap allocator RTL.
// Depends on nothing; users supply the clock and reset names in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FFHA_ASSERT(label, cond, msg)
`define FFHA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_ctrl, ffha_datapath and the top level; depends on nothing.
package ffha_pkg;

   localparam int OPCODE_W = 1;
   localparam int SIZE_W   = 13;
   localparam int ADDR_W   = 12;

   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      RD_RELEASE = 2'd0,
      RD_CUR     = 2'd1,
      RD_NEXT    = 2'd2
   } rd_src_type;

   typedef enum logic [2:0] {
      WR_RELEASE = 3'd0,
      WR_MERGE   = 3'd1,
      WR_TAIL    = 3'd2,
      WR_HEAD    = 3'd3,
      WR_WHOLE   = 3'd4
   } wr_src_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_src_type rd_src;
      logic       wr_en;
      wr_src_type wr_src;
      logic       sz_load;
      logic       adv_en;
      logic       adv_saved;
      logic       rsp_load;
      logic       rsp_found;
      logic       rsp_fail;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic rel_ok;
      logic size_zero;
      logic too_big;
      logic cur_bad;
      logic cur_free;
      logic cur_fit;
      logic cur_last;
      logic nxt_ok;
      logic split_ok;
   } status_type;

endpackage

>>> hw/rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator over an implicit list of block headers.
// Top level; depends on ffha_pkg, ffha_ctrl and ffha_datapath.
//
// Usage: one request channel (req_*) carries allocate or release transactions; the result
// channel (rsp_*) returns exactly one transaction per request, in order. An allocate
// returns the payload offset of the block it claimed, or offset 0 with rsp_failed set when
// the size is zero or no free block fits. A release always returns offset 0, not failed.
// A release reads the addressed header and writes it back marked free; a null or misplaced
// release and a zero or oversized allocate go straight to the result. An allocate reads
// each header in turn and, at a free block too small for the request, probes its successor
// and merges it when free; it then takes a block whole or splits it, or fails when the scan
// finds no fit. The header memory is single-ported and read once per visit, so throughput
// depends on fragmentation of the arena. Requests are processed one at a time; the next
// request is taken in the cycle after the previous result reaches the output register, even
// while that result still waits for rsp_ready.
// Reset: synchronous and active high. It leaves one free block that spans the whole
// arena; no clearing pass is needed, so requests are taken in the first cycle after reset.
// Stalls: when rsp_ready is low the result holds in the output register, the block
// finishes at most one further request and then waits with req_ready low.
module first_fit_heap_allocator_core #(
   parameter int HEAP_BYTES      = 4096,
   parameter int ALIGN_BYTES     = 8,
   parameter int HEADER_BYTES    = 8,
   parameter int MIN_BLOCK_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffha_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ffha_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_block_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_payload_address,
   output logic                          rsp_failed
);

   ffha_pkg::cmd_type    cmd;
   ffha_pkg::status_type status;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .HEAP_BYTES      (HEAP_BYTES),
      .ALIGN_BYTES     (ALIGN_BYTES),
      .HEADER_BYTES    (HEADER_BYTES),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_opcode          (req_opcode),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .cmd                 (cmd),
      .status              (status),
      .rsp_payload_address (rsp_payload_address),
      .rsp_failed          (rsp_failed)
   );

endmodule

>>> hw/rtl/ffha_datapath.sv
// Datapath of the heap allocator: header memory, scan pointer and result register.
// Depends on ffha_pkg; driven by ffha_ctrl through command and status structs.
module ffha_datapath #(
   parameter int HEAP_BYTES      = 4096,
   parameter int ALIGN_BYTES     = 8,
   parameter int HEADER_BYTES    = 8,
   parameter int MIN_BLOCK_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ffha_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ffha_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_block_address,
   input  ffha_pkg::cmd_type             cmd,
   output ffha_pkg::status_type          status,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_payload_address,
   output logic                          rsp_failed
);

   localparam int AW    = $clog2(HEAP_BYTES);
   localparam int SZ_W  = AW + 1;
   localparam int SH    = $clog2(ALIGN_BYTES);
   localparam int IDX_W = AW - SH;
   localparam int DEPTH = HEAP_BYTES / ALIGN_BYTES;
   localparam int CW    = ((SZ_W > ffha_pkg::SIZE_W + 1) ? SZ_W : ffha_pkg::SIZE_W + 1) + 1;
   localparam int MIN_EFF = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

   localparam logic [CW-1:0]   HEAP_C   = CW'(HEAP_BYTES);
   localparam logic [CW-1:0]   MIN_C    = CW'(MIN_EFF);
   localparam logic [CW-1:0]   HDR_C    = CW'(HEADER_BYTES);
   localparam logic [CW-1:0]   ROUND_C  = CW'(HEADER_BYTES + ALIGN_BYTES - 1);
   localparam logic [SZ_W-1:0] ENTRY0_C = SZ_W'(HEAP_BYTES);

   logic [SZ_W-1:0]  mem [DEPTH];
   logic [SZ_W-1:0]  rdata_ff;
   logic             ovr_ff, ovr_in;
   logic             e0_ff, e0_in;

   logic [ffha_pkg::OPCODE_W-1:0] op_ff;
   logic             zero_ff, big_ff, rel_ok_ff;
   logic [IDX_W-1:0] rel_idx_ff;
   logic [AW-1:0]    h_ff, h_in;
   logic [SZ_W-1:0]  sz_ff;
   logic [CW-1:0]    need_ff;
   logic [ffha_pkg::ADDR_W-1:0] pay_ff;
   logic             fail_ff;

   logic [CW-1:0]    need_raw, need_al, need_in;
   logic [CW-1:0]    rel_h;
   logic [SZ_W-1:0]  rd_val, rd_sz;
   logic [CW-1:0]    h_ext, sz_ext, rd_ext, diff;
   logic [CW-1:0]    tail_off, next_off, adv_sum;
   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic [SZ_W-1:0]  wr_data;

   assign need_raw = CW'(req_request_size) + ROUND_C;
   assign need_al  = {need_raw[CW-1:SH], SH'(0)};
   assign need_in  = (need_al < MIN_C) ? MIN_C : need_al;
   assign rel_h    = CW'(req_block_address) - HDR_C;

   assign rd_val = ovr_ff ? ENTRY0_C : rdata_ff;
   assign rd_sz  = {rd_val[SZ_W-1:1], 1'b0};
   assign h_ext  = CW'(h_ff);
   assign sz_ext = CW'(sz_ff);
   assign rd_ext = CW'(rd_sz);
   assign diff   = sz_ext - need_ff;

   assign tail_off = h_ext + need_ff;
   assign next_off = h_ext + sz_ext;
   assign adv_sum  = h_ext + (cmd.adv_saved ? sz_ext : rd_ext);

   always_comb begin
      status.is_release = (op_ff == ffha_pkg::OP_RELEASE);
      status.rel_ok     = rel_ok_ff;
      status.size_zero  = zero_ff;
      status.too_big    = big_ff;
      status.cur_bad    = (rd_sz == '0) || (rd_ext > HEAP_C - h_ext);
      status.cur_free   = !rd_val[0];
      status.cur_fit    = (rd_ext >= need_ff);
      status.cur_last   = (h_ext + rd_ext >= HEAP_C);
      status.nxt_ok     = !rd_val[0] && (rd_sz != '0) && (rd_ext <= HEAP_C - next_off);
      status.split_ok   = (diff >= MIN_C);
   end

   always_comb begin
      case (cmd.rd_src)
         ffha_pkg::RD_RELEASE: rd_idx = rel_idx_ff;
         ffha_pkg::RD_CUR:     rd_idx = h_ff[AW-1:SH];
         ffha_pkg::RD_NEXT:    rd_idx = next_off[AW-1:SH];
         default:              rd_idx = h_ff[AW-1:SH];
      endcase
   end

   always_comb begin
      wr_idx  = h_ff[AW-1:SH];
      wr_data = '0;
      case (cmd.wr_src)
         ffha_pkg::WR_RELEASE: begin
            wr_idx  = rel_idx_ff;
            wr_data = rd_sz;
         end
         ffha_pkg::WR_MERGE: wr_data = SZ_W'(sz_ext + rd_ext);
         ffha_pkg::WR_TAIL: begin
            wr_idx  = tail_off[AW-1:SH];
            wr_data = SZ_W'(diff);
         end
         ffha_pkg::WR_HEAD:  wr_data = SZ_W'(need_ff) | SZ_W'(1);
         ffha_pkg::WR_WHOLE: wr_data = sz_ff | SZ_W'(1);
         default: wr_data = '0;
      endcase
   end

   assign e0_in  = e0_ff || (cmd.wr_en && (wr_idx == '0));
   assign ovr_in = (rd_idx == '0) && !e0_ff;
   assign h_in   = cmd.accept ? '0 : (cmd.adv_en ? adv_sum[AW-1:0] : h_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_ff <= 1'b0;
      end else begin
         e0_ff <= e0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_idx];
         ovr_ff   <= ovr_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      if (cmd.accept) begin
         op_ff      <= req_opcode;
         zero_ff    <= (req_request_size == '0);
         need_ff    <= need_in;
         big_ff     <= (need_in > HEAP_C);
         rel_ok_ff  <= (CW'(req_block_address) >= HDR_C) && (rel_h[SH-1:0] == '0)
                       && (rel_h < HEAP_C);
         rel_idx_ff <= rel_h[AW-1:SH];
      end
      if (cmd.sz_load) begin
         sz_ff <= rd_sz;
      end
      if (cmd.rsp_load) begin
         pay_ff  <= cmd.rsp_found ? ffha_pkg::ADDR_W'(h_ext + HDR_C) : '0;
         fail_ff <= cmd.rsp_fail;
      end
   end

   assign rsp_payload_address = pay_ff;
   assign rsp_failed          = fail_ff;

endmodule

>>> hw/rtl/ffha_ctrl.sv
// Controller state machine of the heap allocator: handshakes and scan sequencing.
// Depends on ffha_pkg and the assertion macro header; commands ffha_datapath.
`include "first_fit_heap_allocator_core_assert.svh"
module ffha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffha_pkg::status_type status,
   output ffha_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_DECODE    = 10'b0000000010,
      ST_REL_WR    = 10'b0000000100,
      ST_SCAN_RD   = 10'b0000001000,
      ST_SCAN_CHK  = 10'b0000010000,
      ST_NEXT_RD   = 10'b0000100000,
      ST_NEXT_CHK  = 10'b0001000000,
      ST_TAKE      = 10'b0010000000,
      ST_TAKE_HEAD = 10'b0100000000,
      ST_DONE      = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      fail_ff, fail_in;
   logic      found_ff, found_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      fail_in   = fail_ff;
      found_in  = found_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_src    = ffha_pkg::RD_CUR;
      cmd.wr_src    = ffha_pkg::WR_HEAD;
      cmd.rsp_found = found_ff;
      cmd.rsp_fail  = fail_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            fail_in  = 1'b0;
            found_in = 1'b0;
            if (status.is_release) begin
               if (status.rel_ok) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_src = ffha_pkg::RD_RELEASE;
                  state_in   = ST_REL_WR;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (status.size_zero || status.too_big) begin
               fail_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SCAN_CHK;
            end
         end
         ST_REL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = ffha_pkg::WR_RELEASE;
            state_in   = ST_DONE;
         end
         ST_SCAN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.sz_load = 1'b1;
            if (status.cur_bad) begin
               fail_in  = 1'b1;
               state_in = ST_DONE;
            end else if (status.cur_free && status.cur_fit) begin
               state_in = ST_TAKE;
            end else if (status.cur_last) begin
               fail_in  = 1'b1;
               state_in = ST_DONE;
            end else if (status.cur_free) begin
               state_in = ST_NEXT_RD;
            end else begin
               cmd.adv_en = 1'b1;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_NEXT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = ffha_pkg::RD_NEXT;
            state_in   = ST_NEXT_CHK;
         end
         ST_NEXT_CHK: begin
            if (status.nxt_ok) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = ffha_pkg::WR_MERGE;
            end else begin
               cmd.adv_en    = 1'b1;
               cmd.adv_saved = 1'b1;
            end
            state_in = ST_SCAN_RD;
         end
         ST_TAKE: begin
            cmd.wr_en = 1'b1;
            found_in  = 1'b1;
            if (status.split_ok) begin
               cmd.wr_src = ffha_pkg::WR_TAIL;
               state_in   = ST_TAKE_HEAD;
            end else begin
               cmd.wr_src = ffha_pkg::WR_WHOLE;
               state_in   = ST_DONE;
            end
         end
         ST_TAKE_HEAD: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = ffha_pkg::WR_HEAD;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fail_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fail_ff      <= fail_in;
         found_ff     <= found_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FFHA_ASSERT(a_single_port, !(cmd.rd_en && cmd.wr_en), "header memory read and write collide")
   `FFHA_ASSERT(a_no_overwrite, !cmd.rsp_load || !rsp_valid_ff || rsp_ready, "result overwritten")
   `FFHA_ASSERT_NEXT(a_done_holds, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE, "finished transaction left while output stalled")
   `FFHA_ASSERT(a_rsp_from_done, !$rose(rsp_valid_ff) || $past(state_ff == ST_DONE), "result raised outside completion")

endmodule

>>> test/first_fit_heap_allocator_core_tb.sv
// Self-checking testbench for first_fit_heap_allocator_core: allocate and release traffic
// checked against a header-level model of the first-fit heap kept in the testbench.
// Depends on ffha_pkg and first_fit_heap_allocator_core.
`timescale 1ns / 100ps

module first_fit_heap_allocator_core_tb;

   localparam int HEAP_BYTES      = 4096;
   localparam int ALIGN_BYTES     = 8;
   localparam int HEADER_BYTES    = 8;
   localparam int MIN_BLOCK_BYTES = 16;
   localparam int HEADER_SLOTS    = HEAP_BYTES / ALIGN_BYTES;
   localparam int MIN_BLOCK       = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                    * ALIGN_BYTES;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int LONG_HOLD       = 300;
   localparam int QUIET_CYCLES    = 20;
   localparam int PHASE_ITEMS     = 240;

   typedef struct packed {
      logic [ffha_pkg::OPCODE_W-1:0] opcode;
      logic [ffha_pkg::SIZE_W-1:0]   request_size;
      logic [ffha_pkg::ADDR_W-1:0]   block_address;
   } heap_req_type;

   typedef struct packed {
      logic [ffha_pkg::ADDR_W-1:0] payload_address;
      logic                        failed;
   } heap_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [ffha_pkg::OPCODE_W-1:0] req_opcode = ffha_pkg::OP_ALLOC;
   logic [ffha_pkg::SIZE_W-1:0]   req_request_size = '0;
   logic [ffha_pkg::ADDR_W-1:0]   req_block_address = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [ffha_pkg::ADDR_W-1:0]   rsp_payload_address;
   logic                          rsp_failed;

   logic [12:0]                 heap_headers [HEADER_SLOTS];
   bit                          header_written [HEADER_SLOTS];
   logic [ffha_pkg::ADDR_W-1:0] live_payloads [$];
   heap_req_type                pending_requests [$];
   heap_rsp_type                expected_results [$];

   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int stall_cycles = 0;

   first_fit_heap_allocator_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_payload_address (rsp_payload_address),
      .rsp_failed          (rsp_failed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int read_header(int offset);
      int slot;
      slot = offset / ALIGN_BYTES;
      if (slot < HEADER_SLOTS) return int'(heap_headers[slot]);
      return 0;
   endfunction

   function automatic void write_header(int offset, int value);
      int slot;
      slot = offset / ALIGN_BYTES;
      if (slot < HEADER_SLOTS) begin
         heap_headers[slot] = 13'(value);
         header_written[slot] = 1'b1;
      end
   endfunction

   // Walks the block list from the start, coalescing free neighbors of a free block
   // that is too small, and sets found to the header offset of the first free block that fits.
   function automatic bit find_first_fit(int need, output int found);
      int h;
      int v;
      int sz;
      int nv;
      int nsz;
      bit merged;
      h = 0;
      found = 0;
      while (h < HEAP_BYTES) begin
         v = read_header(h);
         sz = v & ~1;
         merged = 1'b0;
         if (sz == 0 || sz > HEAP_BYTES - h) return 1'b0;
         if ((v & 1) == 0) begin
            if (sz >= need) begin
               found = h;
               return 1'b1;
            end
            if (h + sz < HEAP_BYTES) begin
               nv = read_header(h + sz);
               nsz = nv & ~1;
               if ((nv & 1) == 0 && nsz != 0 && nsz <= HEAP_BYTES - h - sz) begin
                  write_header(h, sz + nsz);
                  merged = 1'b1;
               end
            end
         end
         if (!merged) h += sz;
      end
      return 1'b0;
   endfunction

   function automatic heap_rsp_type apply_heap_request(heap_req_type r);
      heap_rsp_type res;
      int h;
      int need;
      int blk;
      res.payload_address = '0;
      res.failed = 1'b0;
      if (r.opcode == ffha_pkg::OP_RELEASE) begin
         if (int'(r.block_address) >= HEADER_BYTES) begin
            h = int'(r.block_address) - HEADER_BYTES;
            if (h % ALIGN_BYTES == 0 && h < HEAP_BYTES) write_header(h, read_header(h) & ~1);
         end
         for (int i = live_payloads.size() - 1; i >= 0; i--)
            if (live_payloads[i] == r.block_address) live_payloads.delete(i);
         return res;
      end
      if (r.request_size == '0) begin
         res.failed = 1'b1;
         return res;
      end
      need = ((int'(r.request_size) + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
             * ALIGN_BYTES;
      if (need < MIN_BLOCK) need = MIN_BLOCK;
      if (need > HEAP_BYTES || !find_first_fit(need, h)) begin
         res.failed = 1'b1;
         return res;
      end
      blk = read_header(h) & ~1;
      if (blk - need >= MIN_BLOCK) begin
         write_header(h + need, blk - need);
         write_header(h, need | 1);
      end else begin
         write_header(h, blk | 1);
      end
      res.payload_address = ffha_pkg::ADDR_W'(h + HEADER_BYTES);
      live_payloads.push_back(res.payload_address);
      return res;
   endfunction

   always @(posedge clock) begin : request_driver
      heap_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            item.opcode = req_opcode;
            item.request_size = req_request_size;
            item.block_address = req_block_address;
            expected_results.push_back(apply_heap_request(item));
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               item = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_opcode <= item.opcode;
               req_request_size <= item.request_size;
               req_block_address <= item.block_address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      heap_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction: payload_address %0d failed %0b",
                   rsp_payload_address, rsp_failed);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload_address !== want.payload_address) begin
               $error("payload_address mismatch: expected %0d, actual %0d",
                      want.payload_address, rsp_payload_address);
               mismatch_count++;
            end
            if (rsp_failed !== want.failed) begin
               $error("failed mismatch: expected %0b, actual %0b", want.failed, rsp_failed);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("first_fit_heap_allocator_core_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic queue_request(logic [ffha_pkg::OPCODE_W-1:0] op, int size, int addr);
      heap_req_type item;
      item.opcode = op;
      item.request_size = ffha_pkg::SIZE_W'(size);
      item.block_address = ffha_pkg::ADDR_W'(addr);
      while (pending_requests.size() >= 2) @(negedge clock);
      pending_requests.push_back(item);
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int p;
      int size;
      int addr;
      for (int i = 0; i < HEADER_SLOTS; i++) begin
         heap_headers[i] = '0;
         header_written[i] = 1'b0;
      end
      heap_headers[0] = 13'(HEAP_BYTES);
      header_written[0] = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero size, oversize, minimum blocks and misplaced or null releases.
      queue_request(ffha_pkg::OP_ALLOC, 0, $urandom_range(4095));
      queue_request(ffha_pkg::OP_ALLOC, 4096, 4095);
      queue_request(ffha_pkg::OP_ALLOC, 1, 0);
      queue_request(ffha_pkg::OP_ALLOC, 8, 0);
      queue_request(ffha_pkg::OP_ALLOC, 9, 0);
      queue_request(ffha_pkg::OP_ALLOC, 4072, 0);
      queue_request(ffha_pkg::OP_RELEASE, 8191, 0);
      queue_request(ffha_pkg::OP_RELEASE, 0, 4);
      queue_request(ffha_pkg::OP_RELEASE, 0, 13);
      queue_request(ffha_pkg::OP_RELEASE, 4096, 4095);
      queue_request(ffha_pkg::OP_RELEASE, 0, 24);
      queue_request(ffha_pkg::OP_RELEASE, 0, 24);
      queue_request(ffha_pkg::OP_RELEASE, 0, 8);
      // Merge of two small free blocks, then a whole-block take.
      queue_request(ffha_pkg::OP_ALLOC, 16, 0);
      queue_request(ffha_pkg::OP_RELEASE, 0, 8);
      queue_request(ffha_pkg::OP_RELEASE, 0, 40);
      // Merge across the arena with a split that leaves exactly a minimum block.
      queue_request(ffha_pkg::OP_ALLOC, 4072, 0);
      queue_request(ffha_pkg::OP_RELEASE, 0, 8);
      queue_request(ffha_pkg::OP_ALLOC, 4080, 0);
      queue_request(ffha_pkg::OP_ALLOC, 1, 0);
      queue_request(ffha_pkg::OP_RELEASE, 0, 4088);
      queue_request(ffha_pkg::OP_RELEASE, 0, 8);
      queue_request(ffha_pkg::OP_ALLOC, 4088, 4095);
      queue_request(ffha_pkg::OP_RELEASE, 0, 8);

      for (int phase = 0; phase < 5; phase++) begin
         wait_for_drain();
         case (phase)
            1: begin sender_idle_pct = 51; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 51; end
            3: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         if (phase == 0) hold_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            p = $urandom_range(99);
            if (p < 3) begin
               queue_request(ffha_pkg::OP_RELEASE, $urandom_range(4096), 0);
            end else if (p < 6) begin
               addr = $urandom_range(4095);
               if (addr[2:0] == 3'd0) addr[1] = 1'b1;
               queue_request(ffha_pkg::OP_RELEASE, $urandom_range(4096), addr);
            end else if (p < 10) begin
               addr = $urandom_range(1, HEADER_SLOTS - 1) * ALIGN_BYTES;
               if (!header_written[addr / ALIGN_BYTES - 1]) addr = 0;
               queue_request(ffha_pkg::OP_RELEASE, $urandom_range(4096), addr);
            end else if (p < 55 && live_payloads.size() > 0) begin
               addr = live_payloads[$urandom_range(live_payloads.size() - 1)];
               queue_request(ffha_pkg::OP_RELEASE, $urandom_range(4096), addr);
            end else begin
               p = $urandom_range(99);
               if (p == 0) size = 0;
               else if (p == 1) size = 4096;
               else if (p < 70) size = $urandom_range(1, 64);
               else if (p < 92) size = $urandom_range(65, 512);
               else size = $urandom_range(513, 4095);
               queue_request(ffha_pkg::OP_ALLOC, size, $urandom_range(4095));
            end
         end
      end

      wait_for_drain();
      repeat (QUIET_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("first_fit_heap_allocator_core_tb passed");
      end else begin
         $display("first_fit_heap_allocator_core_tb failed");
      end
      $finish;
   end

endmodule
